>>> rtl/core/ukt_pkg.sv
// ----------------------------------------------------------------------------
// ukt_pkg
// Shared types and constants for the sorted unique key table.
// ----------------------------------------------------------------------------
package ukt_pkg;

   localparam int CAPACITY      = 32;
   localparam int PAYLOAD_BYTES = 8;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [63:0] PAYLOAD_MASK =
      (PAYLOAD_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * PAYLOAD_BYTES)) - 64'd1);

   // request codes
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_DELETE = 2'd1;
   localparam logic [1:0] FUNC_LIST   = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DUP      = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   typedef logic [IDX_W-1:0] addr_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic [5:0]       total_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] key;
      logic [63:0]        payload;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] out_key;
      logic [63:0]        out_payload;
      logic [5:0]         entry_total;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [63:0]        payload;
   } entry_type;

   typedef struct packed {
      logic      we;
      addr_type  waddr;
      entry_type wdata;
      logic      re;
      addr_type  raddr;
   } mem_cmd_type;

   typedef struct packed {
      logic    load;
      rsp_type data;
   } rsp_load_type;

   typedef struct packed {
      logic      busy;
      count_type count;
   } ctrl_stat_type;

endpackage

>>> rtl/core/ukt_mem.sv
// ----------------------------------------------------------------------------
// ukt_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ukt_mem (
   input  logic                 clock,
   input  ukt_pkg::mem_cmd_type cmd,
   output ukt_pkg::entry_type   rd_data
);

   ukt_pkg::entry_type mem_array [ukt_pkg::CAPACITY];
   ukt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem_array[cmd.waddr] <= cmd.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.re) begin
         rd_data_ff <= mem_array[cmd.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ukt_ctrl.sv
// ----------------------------------------------------------------------------
// ukt_ctrl
// Sequencer: walks the entry memory in ascending order to search, shift in
// place on insert or delete, and stream the listing.
// ----------------------------------------------------------------------------
module ukt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ukt_pkg::req_type      req_data,
   input  logic                  slot_free,
   input  ukt_pkg::entry_type    rd_data,
   output ukt_pkg::mem_cmd_type  mem_cmd,
   output ukt_pkg::rsp_load_type rsp_load,
   output ukt_pkg::ctrl_stat_type stat
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INS  = 3'd1;
   localparam logic [2:0] S_DEL  = 3'd2;
   localparam logic [2:0] S_LIST = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0]          state_ff, state_in;
   ukt_pkg::count_type  count_ff, count_in;
   ukt_pkg::count_type  idx_ff, idx_in;
   logic signed [31:0]  key_ff, key_in;
   logic [63:0]         pay_ff, pay_in;
   logic                mode_ff, mode_in;
   ukt_pkg::entry_type  carry_ff, carry_in;
   logic [2:0]          status_ff, status_in;

   ukt_pkg::count_type  idx_inc;
   logic                more;
   logic                at_end;
   logic                is_full;
   ukt_pkg::entry_type  new_entry;

   assign idx_inc   = idx_ff + ukt_pkg::count_type'(1);
   assign more      = (idx_inc < count_ff);
   assign at_end    = (idx_ff == count_ff);
   assign is_full   = (count_ff == ukt_pkg::count_type'(ukt_pkg::CAPACITY));
   assign new_entry = '{key: key_ff, payload: pay_ff};

   assign req_ready  = (state_ff == S_IDLE);
   assign stat.busy  = (state_ff != S_IDLE);
   assign stat.count = count_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      key_in    = key_ff;
      pay_in    = pay_ff;
      mode_in   = mode_ff;
      carry_in  = carry_ff;
      status_in = status_ff;
      mem_cmd   = '0;
      rsp_load  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in  = (req_data.func == ukt_pkg::FUNC_LIST) ? '0 : req_data.key;
               pay_in  = req_data.payload & ukt_pkg::PAYLOAD_MASK;
               idx_in  = '0;
               mode_in = 1'b0;
               unique case (req_data.func)
                  ukt_pkg::FUNC_INSERT: begin
                     mem_cmd.re = 1'b1;
                     state_in   = S_INS;
                  end
                  ukt_pkg::FUNC_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ukt_pkg::ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        mem_cmd.re = 1'b1;
                        state_in   = S_DEL;
                     end
                  end
                  ukt_pkg::FUNC_LIST: begin
                     if (count_ff == '0) begin
                        status_in = ukt_pkg::ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        mem_cmd.re = 1'b1;
                        state_in   = S_LIST;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_INS: begin
            mem_cmd.re    = more;
            mem_cmd.raddr = idx_inc[ukt_pkg::IDX_W-1:0];
            mem_cmd.waddr = idx_ff[ukt_pkg::IDX_W-1:0];
            if (!mode_ff) begin
               priority if (at_end) begin
                  if (is_full) begin
                     status_in = ukt_pkg::ST_FULL;
                  end else begin
                     mem_cmd.we    = 1'b1;
                     mem_cmd.wdata = new_entry;
                     count_in      = count_ff + ukt_pkg::count_type'(1);
                     status_in     = ukt_pkg::ST_OK;
                  end
                  state_in = S_RESP;
               end else if (rd_data.key == key_ff) begin
                  status_in = ukt_pkg::ST_DUP;
                  state_in  = S_RESP;
               end else if (rd_data.key > key_ff) begin
                  if (is_full) begin
                     status_in = ukt_pkg::ST_FULL;
                     state_in  = S_RESP;
                  end else begin
                     // new key takes this slot, the old entry rides along
                     mem_cmd.we    = 1'b1;
                     mem_cmd.wdata = new_entry;
                     carry_in      = rd_data;
                     mode_in       = 1'b1;
                     idx_in        = idx_inc;
                  end
               end else begin
                  idx_in = idx_inc;
               end
            end else begin
               mem_cmd.we    = 1'b1;
               mem_cmd.wdata = carry_ff;
               if (at_end) begin
                  count_in  = count_ff + ukt_pkg::count_type'(1);
                  status_in = ukt_pkg::ST_OK;
                  state_in  = S_RESP;
               end else begin
                  carry_in = rd_data;
                  idx_in   = idx_inc;
               end
            end
         end

         S_DEL: begin
            mem_cmd.re    = more;
            mem_cmd.raddr = idx_inc[ukt_pkg::IDX_W-1:0];
            mem_cmd.waddr = ukt_pkg::addr_type'(idx_ff - ukt_pkg::count_type'(1));
            if (!mode_ff) begin
               priority if (at_end) begin
                  status_in = ukt_pkg::ST_NOTFOUND;
                  state_in  = S_RESP;
               end else if (rd_data.key == key_ff) begin
                  mode_in = 1'b1;
                  idx_in  = idx_inc;
               end else if (rd_data.key > key_ff) begin
                  status_in = ukt_pkg::ST_NOTFOUND;
                  state_in  = S_RESP;
               end else begin
                  idx_in = idx_inc;
               end
            end else begin
               if (at_end) begin
                  count_in  = count_ff - ukt_pkg::count_type'(1);
                  status_in = ukt_pkg::ST_OK;
                  state_in  = S_RESP;
               end else begin
                  // pull each later entry down one slot
                  mem_cmd.we    = 1'b1;
                  mem_cmd.wdata = rd_data;
                  idx_in        = idx_inc;
               end
            end
         end

         S_LIST: begin
            // read data holds until the result slot takes it
            if (slot_free) begin
               rsp_load.load             = 1'b1;
               rsp_load.data.status      = ukt_pkg::ST_OK;
               rsp_load.data.out_key     = rd_data.key;
               rsp_load.data.out_payload = rd_data.payload;
               rsp_load.data.entry_total = ukt_pkg::total_type'(count_ff);
               rsp_load.data.last        = ~more;
               if (more) begin
                  mem_cmd.re    = 1'b1;
                  mem_cmd.raddr = idx_inc[ukt_pkg::IDX_W-1:0];
                  idx_in        = idx_inc;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_RESP: begin
            if (slot_free) begin
               rsp_load.load             = 1'b1;
               rsp_load.data.status      = status_ff;
               rsp_load.data.out_key     = key_ff;
               rsp_load.data.out_payload = '0;
               rsp_load.data.entry_total = ukt_pkg::total_type'(count_ff);
               rsp_load.data.last        = 1'b1;
               state_in                  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         mode_ff  <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      key_ff    <= key_in;
      pay_ff    <= pay_in;
      carry_ff  <= carry_in;
      status_ff <= status_in;
   end

endmodule

>>> rtl/core/sorted_unique_key_table.sv
// ----------------------------------------------------------------------------
// sorted_unique_key_table
// Insert, delete: one ascending walk of the entry memory, then the result is
//   loaded into the result register; the next request is taken after the
//   result is loaded.
// Rejects end the walk as soon as they are decided.
// List: one result per cycle while the result side is ready; the next request
//   is taken after the last result is loaded.
// Reset clears the entry count and control; memory contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_unique_key_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ukt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ukt_pkg::rsp_type rsp_data
);

   ukt_pkg::mem_cmd_type   mem_cmd;
   ukt_pkg::entry_type     rd_data;
   ukt_pkg::rsp_load_type  rsp_load;
   ukt_pkg::ctrl_stat_type stat;

   logic             rsp_valid_ff, rsp_valid_in;
   ukt_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             slot_free;

   ukt_mem u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (rd_data)
   );

   ukt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .slot_free (slot_free),
      .rd_data   (rd_data),
      .mem_cmd   (mem_cmd),
      .rsp_load  (rsp_load),
      .stat      (stat)
   );

   assign slot_free = ~rsp_valid_ff | rsp_ready;

   // result register: frees the sequencer while a transaction waits
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_load.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load.load |-> slot_free)
      else $error("result register overwritten while held");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= ukt_pkg::count_type'(ukt_pkg::CAPACITY))
      else $error("entry count beyond capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(stat.count) |->
         (stat.count == $past(stat.count) + ukt_pkg::count_type'(1)) ||
         (stat.count + ukt_pkg::count_type'(1) == $past(stat.count)))
      else $error("entry count moved by more than one");

   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !stat.busy)
      else $error("request taken while sequencer busy");
`endif

endmodule

>>> bench/sorted_unique_key_table_tb.sv
// ----------------------------------------------------------------------------
// sorted_unique_key_table testbench
// Drives insert, delete and list transactions through the request channel and
// checks every result against a behavioral copy of the sorted key table or a
// typed value. A short table of directed requests covers the extremes and the
// empty, duplicate and not-found rejects. A random phase then fills the table
// to capacity and drains it again while both channels idle and stall.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ukt_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 150;

   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
   localparam logic [1:0]         FUNC_UNUSED = 2'd3;

   typedef enum logic [1:0] {RX_STEADY, RX_JITTER, RX_CHOKED} rx_mode_type;

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type rsp;
   } dir_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the table
   logic signed [31:0] table_keys     [CAPACITY];
   logic [63:0]        table_payloads [CAPACITY];
   int                 table_count = 0;

   rsp_type expected_rsps [$];

   int error_count     = 0;
   int requests_sent   = 0;
   int results_checked = 0;
   int status_seen [5] = '{default: 0};
   int burst_left      = 0;

   rx_mode_type rx_mode = RX_STEADY;
   int          rx_left = 0;

   // rows with a typed result are checked against that value directly
   dir_row_type directed_rows [25] = '{
      '{'{FUNC_LIST,   32'sd0, 64'd0}, 1'b1, '{ST_EMPTY, 32'sd0, 64'd0, 6'd0, 1'b1}},
      '{'{FUNC_DELETE, 32'sd5, 64'd0}, 1'b1, '{ST_EMPTY, 32'sd5, 64'd0, 6'd0, 1'b1}},
      '{'{FUNC_INSERT, KEY_MIN, {64{1'b1}}}, 1'b1, '{ST_OK, KEY_MIN, 64'd0, 6'd1, 1'b1}},
      '{'{FUNC_INSERT, KEY_MAX, 64'd0}, 1'b1, '{ST_OK, KEY_MAX, 64'd0, 6'd2, 1'b1}},
      '{'{FUNC_INSERT, 32'sd0, 64'h0123_4567_89ab_cdef}, 1'b1,
        '{ST_OK, 32'sd0, 64'd0, 6'd3, 1'b1}},
      '{'{FUNC_INSERT, -32'sd1, 64'h8000_0000_0000_0001}, 1'b1,
        '{ST_OK, -32'sd1, 64'd0, 6'd4, 1'b1}},
      '{'{FUNC_INSERT, 32'sd0, 64'h5555_5555_5555_5555}, 1'b1,
        '{ST_DUP, 32'sd0, 64'd0, 6'd4, 1'b1}},
      '{'{FUNC_INSERT, 32'sd1, 64'haaaa_aaaa_aaaa_aaaa}, 1'b1,
        '{ST_OK, 32'sd1, 64'd0, 6'd5, 1'b1}},
      '{'{FUNC_LIST,   32'sd9, 64'd7}, 1'b0, '0},
      '{'{FUNC_DELETE, 32'sd12345, 64'd0}, 1'b1,
        '{ST_NOTFOUND, 32'sd12345, 64'd0, 6'd5, 1'b1}},
      '{'{FUNC_UNUSED, 32'sd7, 64'hff}, 1'b0, '0},
      '{'{FUNC_DELETE, 32'sd0, 64'd0}, 1'b1, '{ST_OK, 32'sd0, 64'd0, 6'd4, 1'b1}},
      '{'{FUNC_DELETE, KEY_MIN, 64'd0}, 1'b1, '{ST_OK, KEY_MIN, 64'd0, 6'd3, 1'b1}},
      '{'{FUNC_DELETE, KEY_MAX, 64'd0}, 1'b1, '{ST_OK, KEY_MAX, 64'd0, 6'd2, 1'b1}},
      '{'{FUNC_LIST,   32'sd0, 64'd0}, 1'b0, '0},
      '{'{FUNC_INSERT, 32'sh7fff_fffe, 64'hdead_beef_0000_ffff}, 1'b1,
        '{ST_OK, 32'sh7fff_fffe, 64'd0, 6'd3, 1'b1}},
      '{'{FUNC_INSERT, 32'sh8000_0001, 64'h0000_ffff_beef_dead}, 1'b1,
        '{ST_OK, 32'sh8000_0001, 64'd0, 6'd4, 1'b1}},
      '{'{FUNC_LIST,   32'sd0, 64'd0}, 1'b0, '0},
      '{'{FUNC_DELETE, -32'sd1, 64'd0}, 1'b1, '{ST_OK, -32'sd1, 64'd0, 6'd3, 1'b1}},
      '{'{FUNC_DELETE, 32'sd1, 64'd0}, 1'b1, '{ST_OK, 32'sd1, 64'd0, 6'd2, 1'b1}},
      '{'{FUNC_DELETE, 32'sh7fff_fffe, 64'd0}, 1'b1,
        '{ST_OK, 32'sh7fff_fffe, 64'd0, 6'd1, 1'b1}},
      '{'{FUNC_DELETE, 32'sh8000_0001, 64'd0}, 1'b1,
        '{ST_OK, 32'sh8000_0001, 64'd0, 6'd0, 1'b1}},
      '{'{FUNC_DELETE, 32'sd1, 64'd0}, 1'b1, '{ST_EMPTY, 32'sd1, 64'd0, 6'd0, 1'b1}},
      '{'{FUNC_LIST,   32'sd3, 64'd3}, 1'b1, '{ST_EMPTY, 32'sd0, 64'd0, 6'd0, 1'b1}},
      '{'{FUNC_UNUSED, KEY_MIN, {64{1'b1}}}, 1'b0, '0}
   };

   sorted_unique_key_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int find_entry(input logic signed [31:0] k);
      for (int i = 0; i < table_count; i++)
         if (table_keys[i] == k)
            return i;
      return -1;
   endfunction

   function automatic logic signed [31:0] pick_key();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            v = $urandom_range(0, 200);
            return v - 100;
         end
         5, 6, 7: return $urandom;
         default: begin
            case ($urandom_range(0, 5))
               0: return KEY_MIN;
               1: return KEY_MIN + 32'sd1;
               2: return KEY_MAX;
               3: return KEY_MAX - 32'sd1;
               4: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
      endcase
   endfunction

   // updates the shadow table and returns the results one request causes
   task automatic predict_table_op(input req_type r, output rsp_type outs [$]);
      int at;
      int pos;
      outs = {};
      case (r.func)
         FUNC_INSERT: begin
            at = find_entry(r.key);
            if (at >= 0) begin
               outs.push_back(rsp_type'{ST_DUP, r.key, 64'd0, total_type'(table_count), 1'b1});
            end else if (table_count >= CAPACITY) begin
               outs.push_back(rsp_type'{ST_FULL, r.key, 64'd0, total_type'(table_count), 1'b1});
            end else begin
               pos = 0;
               while (pos < table_count && table_keys[pos] < r.key)
                  pos++;
               for (int i = table_count; i > pos; i--) begin
                  table_keys[i]     = table_keys[i-1];
                  table_payloads[i] = table_payloads[i-1];
               end
               table_keys[pos]     = r.key;
               table_payloads[pos] = r.payload & PAYLOAD_MASK;
               table_count++;
               outs.push_back(rsp_type'{ST_OK, r.key, 64'd0, total_type'(table_count), 1'b1});
            end
         end
         FUNC_DELETE: begin
            at = find_entry(r.key);
            if (table_count == 0) begin
               outs.push_back(rsp_type'{ST_EMPTY, r.key, 64'd0, 6'd0, 1'b1});
            end else if (at < 0) begin
               outs.push_back(rsp_type'{ST_NOTFOUND, r.key, 64'd0,
                                        total_type'(table_count), 1'b1});
            end else begin
               for (int i = at; i + 1 < table_count; i++) begin
                  table_keys[i]     = table_keys[i+1];
                  table_payloads[i] = table_payloads[i+1];
               end
               table_count--;
               outs.push_back(rsp_type'{ST_OK, r.key, 64'd0, total_type'(table_count), 1'b1});
            end
         end
         FUNC_LIST: begin
            if (table_count == 0)
               outs.push_back(rsp_type'{ST_EMPTY, 32'sd0, 64'd0, 6'd0, 1'b1});
            for (int i = 0; i < table_count; i++)
               outs.push_back(rsp_type'{ST_OK, table_keys[i], table_payloads[i],
                                        total_type'(table_count), (i + 1 == table_count)});
         end
         default: ;
      endcase
   endtask

   // sender: bursts of back-to-back transactions separated by random gaps
   task automatic send_request(input req_type r, input logic typed, input rsp_type typed_rsp);
      rsp_type outs [$];
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      req_data  = r;
      req_valid = 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_table_op(r, outs);
      if (typed)
         outs = {typed_rsp};
      foreach (outs[i]) begin
         expected_rsps.push_back(outs[i]);
         status_seen[outs[i].status]++;
      end
      requests_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // receiver: switches between steady, jittery and choked stretches
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(4, 40);
      end
      rx_left--;
      case (rx_mode)
         RX_STEADY: rsp_ready = 1'b1;
         RX_JITTER: rsp_ready = $urandom_range(0, 1);
         default:   rsp_ready = ($urandom_range(0, 4) == 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            results_checked++;
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %h got %h", $time, want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.out_key !== want.out_key) begin
               $display("%0t: out_key expected %h got %h", $time, want.out_key,
                        rsp_data.out_key);
               error_count++;
            end
            if (rsp_data.out_payload !== want.out_payload) begin
               $display("%0t: out_payload expected %h got %h", $time, want.out_payload,
                        rsp_data.out_payload);
               error_count++;
            end
            if (rsp_data.entry_total !== want.entry_total) begin
               $display("%0t: entry_total expected %0d got %0d", $time, want.entry_total,
                        rsp_data.entry_total);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $display("%0t: last expected %b got %b", $time, want.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      req_type r;
      int      roll;
      int      sent;
      int      insert_share;
      logic    growing;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      // random phase: alternate filling to capacity and draining to empty
      sent    = 0;
      growing = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         roll         = $urandom_range(0, 99);
         insert_share = growing ? 75 : 15;
         r.payload    = {$urandom, $urandom};
         r.key        = pick_key();
         if (roll < 3)
            r.func = FUNC_UNUSED;
         else if (roll < 11)
            r.func = FUNC_LIST;
         else if (roll < 11 + insert_share)
            r.func = FUNC_INSERT;
         else
            r.func = FUNC_DELETE;
         if (table_count > 0) begin
            if ((r.func == FUNC_INSERT && $urandom_range(0, 4) == 0) ||
                (r.func == FUNC_DELETE && $urandom_range(0, 9) < 6))
               r.key = table_keys[$urandom_range(0, table_count - 1)];
         end
         send_request(r, 1'b0, '0);
         if (r.func != FUNC_UNUSED)
            sent++;

         if (growing && table_count == CAPACITY) begin
            // duplicate beats full, then a fresh key against the full table
            r.func = FUNC_INSERT;
            r.key  = table_keys[$urandom_range(0, CAPACITY - 1)];
            send_request(r, 1'b0, '0);
            do r.key = $urandom; while (find_entry(r.key) >= 0);
            send_request(r, 1'b0, '0);
            r.func = FUNC_LIST;
            send_request(r, 1'b0, '0);
            sent    += 3;
            growing = 1'b0;
         end else if (!growing && table_count == 0) begin
            r.func = FUNC_DELETE;
            r.key  = pick_key();
            send_request(r, 1'b0, '0);
            sent++;
            growing = 1'b1;
         end
      end
      req_valid = 1'b0;

      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d requests, checked %0d results", requests_sent, results_checked);
      $display("status mix: ok %0d, duplicate %0d, not found %0d, full %0d, empty %0d",
               status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_NOTFOUND],
               status_seen[ST_FULL], status_seen[ST_EMPTY]);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> files.f
rtl/core/ukt_pkg.sv
rtl/core/ukt_mem.sv
rtl/core/ukt_ctrl.sv
rtl/core/sorted_unique_key_table.sv
bench/sorted_unique_key_table_tb.sv
